FILE: sv/nca_pkg.sv
`timescale 1ns / 1ps

package nca_pkg;

   // Field widths of the sample and result transactions
   localparam int SAMPLE_W = 16;
   localparam int LAG_W    = 6;
   localparam int CORR_W   = 18;

   // Fraction bits of the normalized result (65536 means 1.0)
   localparam int FRAC_W   = 16;

   // Default frame length, a power of two from 4 to 64
   localparam int DEFAULT_FRAME_LEN = 64;

endpackage

FILE: sv/normalized_circular_autocorrelation.sv
`timescale 1ns / 1ps

// Normalized circular autocorrelation. The block loads a frame of FRAME_LEN signed
// samples, one per cycle while req_ready is high, then returns r[k]/r[0] for lags
// 0..FRAME_LEN/2 in signed fixed point with 16 fraction bits, truncated toward zero;
// rsp_last marks the final lag. An all-zero frame returns FRAME_LEN results of zero
// with lags 0..FRAME_LEN-1. Every lag runs one shared 16x16 multiply-accumulator over
// the whole frame (reading two frame-store ports per cycle, through the read, product
// and accumulator registers), then a one-bit-per-cycle restoring divider, and the
// result is posted once the output register is free. The block takes no samples
// during the computation; the next frame loads while the final result still waits
// in the output register.
module normalized_circular_autocorrelation #(
   parameter int FRAME_LEN = nca_pkg::DEFAULT_FRAME_LEN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [nca_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [nca_pkg::LAG_W-1:0]    rsp_lag,
   output logic signed [nca_pkg::CORR_W-1:0]   rsp_corr,
   output logic                                rsp_last
);
   import nca_pkg::*;

   localparam int IDX_W  = $clog2(FRAME_LEN);
   localparam int HALF   = FRAME_LEN / 2;
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int ACC_W  = PROD_W + IDX_W + 1;
   localparam int QUO_W  = FRAC_W + 1;
   localparam int STEP_W = $clog2(QUO_W);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_DIV,
      ST_EMIT,
      ST_SILENT
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           load_idx_ff, load_idx_in;
   logic                       zero_ff, zero_in;
   logic [IDX_W-1:0]           lag_ff, lag_in;
   logic [IDX_W-1:0]           n_ff, n_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]           r0_ff, r0_in;
   logic [ACC_W:0]             rem_ff, rem_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LAG_W-1:0]           rsp_lag_ff, rsp_lag_in;
   logic signed [CORR_W-1:0]   rsp_corr_ff, rsp_corr_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Frame store and its two registered read ports
   logic signed [SAMPLE_W-1:0] frame_mem [FRAME_LEN];
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]           rd_addr_b;
   logic                       req_take;

   // Divider and result helpers
   logic [ACC_W-1:0]           acc_mag;
   logic                       div_ge;
   logic [ACC_W:0]             div_diff;
   logic                       out_free;
   logic signed [CORR_W-1:0]   quo_signed;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign rd_addr_b = n_ff + lag_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lag   = rsp_lag_ff;
   assign rsp_corr  = rsp_corr_ff;
   assign rsp_last  = rsp_last_ff;

   // Frame store: one write port, two read ports
   always_ff @(posedge clock) begin
      if (req_take) begin
         frame_mem[load_idx_ff] <= req_sample;
      end
      rd_a_ff <= frame_mem[n_ff];
      rd_b_ff <= frame_mem[rd_addr_b];
   end

   // Datapath helpers
   always_comb begin
      acc_mag    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      div_ge     = (rem_ff >= {1'b0, r0_ff});
      div_diff   = div_ge ? (rem_ff - {1'b0, r0_ff}) : rem_ff;
      out_free   = !rsp_valid_ff || rsp_ready;
      quo_signed = neg_ff ? -CORR_W'({1'b0, quo_ff}) : CORR_W'({1'b0, quo_ff});
   end

   // Sequencer next-state logic
   always_comb begin
      state_in     = state_ff;
      load_idx_in  = load_idx_ff;
      zero_in      = zero_ff;
      lag_in       = lag_ff;
      n_in         = n_ff;
      rd_vld_in    = 1'b0;
      prod_vld_in  = rd_vld_ff;
      prod_in      = rd_a_ff * rd_b_ff;
      acc_in       = prod_vld_ff ? (acc_ff + ACC_W'(prod_ff)) : acc_ff;
      r0_in        = r0_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lag_in   = rsp_lag_ff;
      rsp_corr_in  = rsp_corr_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               zero_in = zero_ff && (req_sample == '0);
               if (load_idx_ff == IDX_W'(FRAME_LEN - 1)) begin
                  load_idx_in = '0;
                  lag_in      = '0;
                  n_in        = '0;
                  zero_in     = 1'b1;
                  state_in    = (zero_ff && (req_sample == '0)) ? ST_SILENT : ST_MAC;
               end else begin
                  load_idx_in = load_idx_ff + 1'b1;
               end
            end
         end

         // Issue one product pair per cycle for the current lag
         ST_MAC: begin
            rd_vld_in = 1'b1;
            n_in      = n_ff + 1'b1;
            if (n_ff == IDX_W'(FRAME_LEN - 1)) begin
               state_in = ST_DRAIN;
            end
         end

         // Wait for the last products, then start the divide
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               neg_in  = acc_ff[ACC_W-1];
               rem_in  = {1'b0, acc_mag};
               quo_in  = '0;
               step_in = '0;
               acc_in  = '0;
               if (lag_ff == '0) begin
                  r0_in = ACC_W'(acc_ff);
               end
               state_in = ST_DIV;
            end
         end

         // Restoring divide, one quotient bit per cycle
         ST_DIV: begin
            rem_in  = {div_diff[ACC_W-1:0], 1'b0};
            quo_in  = {quo_ff[QUO_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_W)) begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lag_in   = LAG_W'(lag_ff);
               rsp_corr_in  = quo_signed;
               rsp_last_in  = (lag_ff == IDX_W'(HALF));
               if (lag_ff == IDX_W'(HALF)) begin
                  state_in = ST_LOAD;
               end else begin
                  lag_in   = lag_ff + 1'b1;
                  n_in     = '0;
                  state_in = ST_MAC;
               end
            end
         end

         // All-zero frame: zero results for every lag of the frame
         ST_SILENT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lag_in   = LAG_W'(lag_ff);
               rsp_corr_in  = '0;
               rsp_last_in  = (lag_ff == IDX_W'(FRAME_LEN - 1));
               lag_in       = lag_ff + 1'b1;
               if (lag_ff == IDX_W'(FRAME_LEN - 1)) begin
                  state_in = ST_LOAD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_idx_ff  <= '0;
         zero_ff      <= 1'b1;
         lag_ff       <= '0;
         n_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         zero_ff      <= zero_in;
         lag_ff       <= lag_in;
         n_ff         <= n_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      r0_ff       <= r0_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      rsp_lag_ff  <= rsp_lag_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
